[hw/rtl/rle565_pkg.sv]
package rle565_pkg;

    // Longest run that one record may carry.
    localparam int unsigned RUN_LIMIT = 255;

    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COLOR_W = 16;
    localparam int unsigned LEN_W   = 8;

    // Color order codes of the mode register.
    localparam logic ORDER_RGB = 1'b0;
    localparam logic ORDER_GRB = 1'b1;

    // One run record as it waits in the output queue.
    typedef struct packed {
        logic [LEN_W-1:0]   run_length;
        logic [COLOR_W-1:0] packed_color;
        logic               ends_frame;
        logic               burst_last;
    } t_rec;

    // Pack a 24-bit pixel to 565 form; GRB order swaps the top and middle fields.
    function automatic logic [COLOR_W-1:0] f_pack565(
        input logic              order,
        input logic [CHAN_W-1:0] red,
        input logic [CHAN_W-1:0] green,
        input logic [CHAN_W-1:0] blue
    );
        logic [CHAN_W-1:0] top;
        logic [CHAN_W-1:0] mid;
        top = (order == ORDER_GRB) ? green : red;
        mid = (order == ORDER_GRB) ? red : green;
        return {top[7:3], mid[7:2], blue[7:3]};
    endfunction

endpackage

[hw/rtl/rle565_pix_if.sv]
interface rle565_pix_if
    import rle565_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              frame_last;

    modport source (output valid, output red, output green, output blue,
                    output frame_last, input ready);
    modport sink   (input valid, input red, input green, input blue,
                    input frame_last, output ready);
endinterface

[hw/rtl/rle565_rec_if.sv]
interface rle565_rec_if
    import rle565_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [LEN_W-1:0]   run_length;
    logic [COLOR_W-1:0] packed_color;
    logic               ends_frame;
    logic               burst_last;

    modport source (output valid, output run_length, output packed_color,
                    output ends_frame, output burst_last, input ready);
    modport sink   (input valid, input run_length, input packed_color,
                    input ends_frame, input burst_last, output ready);
endinterface

[hw/rtl/rgb565_run_length_encoder_core.sv]
// A closed record is registered into the record queue, whose head drives the output.
// Throughput: one pixel per cycle while each pixel closes at most one run and the record
// output is not stalled; a pixel that closes two runs can hold off the pixels behind it.
// Pixels are taken while the three-entry record queue holds at most one record.
// Reset (synchronous, active low) empties the queue, closes any open run and sets RGB order.
module rgb565_run_length_encoder_core
    import rle565_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic        i_cfg_wdata,
    rle565_pix_if.sink   i_pix,
    rle565_rec_if.source o_rec
);

    localparam int unsigned QDEPTH = 3;

    logic               r_color_order;
    logic [COLOR_W-1:0] r_run_color;
    logic [LEN_W-1:0]   r_run_count;
    t_rec               r_q [QDEPTH];
    logic [1:0]         r_cnt;

    logic               n_color_order;
    logic [COLOR_W-1:0] n_run_color;
    logic [LEN_W-1:0]   n_run_count;
    t_rec               n_q [QDEPTH];
    logic [1:0]         n_cnt;

    logic               pix_xfer;
    logic               rec_xfer;
    logic [COLOR_W-1:0] color;
    logic               run_open;
    logic               run_close;
    logic [LEN_W-1:0]   new_count;
    logic               push_a;
    logic               push_b;
    logic [1:0]         base;
    logic [1:0]         pos_b;
    t_rec               rec_a;
    t_rec               rec_b;

    // Handshakes: pixels are taken while room for two records is certain.
    assign i_pix.ready = (r_cnt <= 2'd1);
    assign pix_xfer    = i_pix.valid && i_pix.ready;
    assign o_rec.valid = (r_cnt != 2'd0);
    assign rec_xfer    = o_rec.valid && o_rec.ready;

    // The head of the queue drives the output payload.
    assign o_rec.run_length   = r_q[0].run_length;
    assign o_rec.packed_color = r_q[0].packed_color;
    assign o_rec.ends_frame   = r_q[0].ends_frame;
    assign o_rec.burst_last   = r_q[0].burst_last;

    // Run tracking: compare the packed color with the open run and count.
    always_comb begin
        color     = f_pack565(r_color_order, i_pix.red, i_pix.green, i_pix.blue);
        run_open  = (r_run_count != '0);
        run_close = run_open &&
                    ((color != r_run_color) || (r_run_count >= LEN_W'(RUN_LIMIT)));
        new_count = (!run_open || run_close) ? LEN_W'(1) : r_run_count + LEN_W'(1);

        push_a = pix_xfer && run_close;
        push_b = pix_xfer && i_pix.frame_last;

        rec_a.run_length   = r_run_count;
        rec_a.packed_color = r_run_color;
        rec_a.ends_frame   = 1'b0;
        rec_a.burst_last   = !i_pix.frame_last;

        rec_b.run_length   = new_count;
        rec_b.packed_color = color;
        rec_b.ends_frame   = 1'b1;
        rec_b.burst_last   = 1'b1;

        n_run_color = r_run_color;
        n_run_count = r_run_count;
        if (pix_xfer) begin
            n_run_color = color;
            n_run_count = i_pix.frame_last ? '0 : new_count;
        end

        n_color_order = i_cfg_we ? i_cfg_wdata : r_color_order;
    end

    // Record queue: shift out the head on a transfer, then append new records.
    always_comb begin
        base  = r_cnt - {1'b0, rec_xfer};
        pos_b = base + {1'b0, push_a};
        for (int i = 0; i < QDEPTH; i++) begin
            if (rec_xfer && (i < QDEPTH - 1)) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
            if (push_a && (base == 2'(i))) begin
                n_q[i] = rec_a;
            end
            if (push_b && (pos_b == 2'(i))) begin
                n_q[i] = rec_b;
            end
        end
        n_cnt = base + {1'b0, push_a} + {1'b0, push_b};
    end

    // Control state and run state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_order <= ORDER_RGB;
            r_run_color   <= '0;
            r_run_count   <= '0;
            r_cnt         <= '0;
        end else begin
            r_color_order <= n_color_order;
            r_run_color   <= n_run_color;
            r_run_count   <= n_run_count;
            r_cnt         <= n_cnt;
        end
    end

    // Queue payload needs no reset.
    always_ff @(posedge i_clk) begin
        r_q <= n_q;
    end

endmodule

[hw/rtl/rle565_chk.sv]
module rle565_chk
    import rle565_pkg::*;
(
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_pix_valid,
    input logic               i_pix_ready,
    input logic               i_pix_frame_last,
    input logic               i_rec_valid,
    input logic               i_rec_ready,
    input logic [LEN_W-1:0]   i_rec_run_length,
    input logic [COLOR_W-1:0] i_rec_packed_color,
    input logic               i_rec_ends_frame,
    input logic               i_rec_burst_last
);

    // A stalled record stays offered.
    a_rec_hold_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rec_valid && !i_rec_ready |=> i_rec_valid)
        else $error("record valid dropped while stalled");

    // A stalled record keeps its payload.
    a_rec_hold_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rec_valid && !i_rec_ready |=>
            $stable(i_rec_run_length) && $stable(i_rec_packed_color) &&
            $stable(i_rec_ends_frame) && $stable(i_rec_burst_last))
        else $error("record payload changed while stalled");

    // A frame-ending pixel always leaves a record waiting.
    a_frame_record: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pix_valid && i_pix_ready && i_pix_frame_last |=> i_rec_valid)
        else $error("no record after frame end");

    // Records never carry an empty run, and a frame-closing record ends its burst.
    a_rec_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rec_valid |-> (i_rec_run_length != '0) && (!i_rec_ends_frame || i_rec_burst_last))
        else $error("bad record fields");

endmodule

bind rgb565_run_length_encoder_core rle565_chk u_rle565_chk (
    .i_clk              (i_clk),
    .i_rst_n            (i_rst_n),
    .i_pix_valid        (i_pix.valid),
    .i_pix_ready        (i_pix.ready),
    .i_pix_frame_last   (i_pix.frame_last),
    .i_rec_valid        (o_rec.valid),
    .i_rec_ready        (o_rec.ready),
    .i_rec_run_length   (o_rec.run_length),
    .i_rec_packed_color (o_rec.packed_color),
    .i_rec_ends_frame   (o_rec.ends_frame),
    .i_rec_burst_last   (o_rec.burst_last)
);

[bench/tb.sv]
module tb
    import rle565_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    // Generous bound on the whole run, well above the slowest legal schedule.
    localparam int unsigned CYCLE_LIMIT   = 400000;
    // Cycles to let pass once the last record is in, before touching the mode register.
    localparam int unsigned SETTLE_CYCLES = 4;

    // Tracks the open run the way the encoder should and holds the records it must emit.
    class run_tracker;
        logic               order;
        logic [COLOR_W-1:0] run_color;
        logic [LEN_W-1:0]   run_count;
        t_rec               expected_runs[$];
        int unsigned        faults;

        function new();
            order     = ORDER_RGB;
            run_color = '0;
            run_count = '0;
            faults    = 0;
        endfunction

        function int unsigned pending();
            return expected_runs.size();
        endfunction

        // Account for one pixel transfer and queue the records it closes.
        function void take_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                                 input logic [CHAN_W-1:0] b, input logic last);
            logic [CHAN_W-1:0]  top_ch;
            logic [CHAN_W-1:0]  mid_ch;
            logic [COLOR_W-1:0] color;
            t_rec               closed[$];
            top_ch = (order == ORDER_GRB) ? g : r;
            mid_ch = (order == ORDER_GRB) ? r : g;
            color  = {top_ch[7:3], mid_ch[7:2], b[7:3]};

            // A new color or a full run closes the open run.
            if (run_count == '0) begin
                run_color = color;
                run_count = LEN_W'(1);
            end else if (color != run_color || run_count >= RUN_LIMIT) begin
                closed.push_back('{run_length: run_count, packed_color: run_color,
                                   ends_frame: 1'b0, burst_last: 1'b0});
                run_color = color;
                run_count = LEN_W'(1);
            end else begin
                run_count = run_count + 1'b1;
            end

            // The frame end flushes whatever run is open, including this pixel.
            if (last) begin
                closed.push_back('{run_length: run_count, packed_color: run_color,
                                   ends_frame: 1'b1, burst_last: 1'b0});
                run_count = '0;
            end

            if (closed.size() != 0)
                closed[closed.size()-1].burst_last = 1'b1;
            foreach (closed[k])
                expected_runs.push_back(closed[k]);
        endfunction

        // Compare one record transfer against the oldest expected record.
        function void match_record(input t_rec got);
            t_rec want;
            if (expected_runs.size() == 0) begin
                $error("unexpected run record: length %0d color %h", got.run_length,
                       got.packed_color);
                faults++;
                return;
            end
            want = expected_runs.pop_front();
            if (got.run_length !== want.run_length) begin
                $error("run_length: expected %0d, actual %0d", want.run_length, got.run_length);
                faults++;
            end
            if (got.packed_color !== want.packed_color) begin
                $error("packed_color: expected %h, actual %h", want.packed_color,
                       got.packed_color);
                faults++;
            end
            if (got.ends_frame !== want.ends_frame) begin
                $error("ends_frame: expected %b, actual %b", want.ends_frame, got.ends_frame);
                faults++;
            end
            if (got.burst_last !== want.burst_last) begin
                $error("burst_last: expected %b, actual %b", want.burst_last, got.burst_last);
                faults++;
            end
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic        i_cfg_wdata;
    int unsigned cycle_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned sink_idle_pct = 0;
    run_tracker  board = new();

    rle565_pix_if pix_ch();
    rle565_rec_if rec_ch();

    rgb565_run_length_encoder_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_pix       (pix_ch),
        .o_rec       (rec_ch)
    );

    // Clock: 8 ns period.
    always begin
        #4;
        i_clk = 1'b1;
        #4;
        i_clk = 1'b0;
    end

    // Watchdog on the total run length.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // The record receiver stalls at random at the current rate.
    always @(negedge i_clk) begin
        rec_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
    end

    // Every record transfer is checked at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && rec_ch.valid && rec_ch.ready)
            board.match_record('{run_length: rec_ch.run_length,
                                 packed_color: rec_ch.packed_color,
                                 ends_frame: rec_ch.ends_frame,
                                 burst_last: rec_ch.burst_last});
    end

    // Offer one pixel, with random idle cycles first; entered and left at a falling edge.
    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic last);
        while ($urandom_range(99) < src_idle_pct) begin
            pix_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        pix_ch.valid      <= 1'b1;
        pix_ch.red        <= r;
        pix_ch.green      <= g;
        pix_ch.blue       <= b;
        pix_ch.frame_last <= last;
        do
            @(posedge i_clk);
        while (!pix_ch.ready);
        board.take_pixel(r, g, b, last);
        @(negedge i_clk);
    endtask

    // Stop sending and wait until every expected record has been seen.
    task automatic drain();
        pix_ch.valid <= 1'b0;
        while (board.pending() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write the mode register; the encoder is idle when this is called.
    task automatic set_color_order(input logic order);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= order;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        board.order = order;
    endtask

    // Same packed color as the base, with low bits randomized that packing drops in either order.
    task automatic send_jittered(input logic [23:0] base, input logic last);
        send_pixel({base[23:18], 2'($urandom)}, {base[15:10], 2'($urandom)},
                   {base[7:3], 3'($urandom)}, last);
    endtask

    // One long run of a single color, closed by a frame end.
    task automatic long_run(input int unsigned len);
        logic [23:0] base;
        base = 24'($urandom);
        for (int unsigned i = 0; i < len; i++)
            send_jittered(base, i == len - 1);
    endtask

    // Mostly runs of one color, from a small palette or at random, and some lone random pixels.
    task automatic random_traffic(input int unsigned count);
        int unsigned done;
        int unsigned kind;
        int unsigned len;
        logic [23:0] palette[4];
        logic [23:0] base;
        done = 0;
        foreach (palette[k])
            palette[k] = 24'($urandom);
        while (done < count) begin
            kind = $urandom_range(99);
            if (kind < 15) begin
                send_pixel(8'($urandom), 8'($urandom), 8'($urandom), $urandom_range(9) == 0);
                done++;
            end else begin
                len  = (kind < 22) ? $urandom_range(20, 60) : $urandom_range(1, 6);
                base = ($urandom_range(1) == 0) ? palette[$urandom_range(3)] : 24'($urandom);
                for (int unsigned i = 0; i < len; i++)
                    send_jittered(base, (i == len - 1) ? ($urandom_range(3) == 0)
                                                       : ($urandom_range(40) == 0));
                done += len;
            end
        end
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_cfg_we          = 1'b0;
        i_cfg_wdata       = ORDER_RGB;
        pix_ch.valid      = 1'b0;
        pix_ch.red        = '0;
        pix_ch.green      = '0;
        pix_ch.blue       = '0;
        pix_ch.frame_last = 1'b0;
        rec_ch.ready      = 1'b0;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Directed: extreme colors, color changes, frame ends and two-record bursts in RGB.
        send_pixel(8'h00, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b0);
        send_pixel(8'h00, 8'h00, 8'hFF, 1'b1);
        send_pixel(8'h07, 8'h03, 8'h07, 1'b0);
        send_pixel(8'h00, 8'h00, 8'h00, 1'b1);
        send_pixel(8'hF8, 8'hFC, 8'hF8, 1'b0);
        send_pixel(8'hFF, 8'hFF, 8'hFF, 1'b1);
        drain();

        // Directed: the same kinds of pixels with green packed on top.
        set_color_order(ORDER_GRB);
        send_pixel(8'hFF, 8'h00, 8'h00, 1'b0);
        send_pixel(8'h00, 8'hFF, 8'h00, 1'b1);
        send_pixel(8'h80, 8'h40, 8'h20, 1'b1);
        send_pixel(8'h07, 8'h03, 8'h07, 1'b0);
        send_pixel(8'h04, 8'hFF, 8'h07, 1'b1);
        drain();

        // Sender idles lightly, receiver stalls heavily.
        src_idle_pct  = 23;
        sink_idle_pct = 88;
        random_traffic(120);
        drain();

        // Roles swapped; a run long enough to be split at the limit.
        set_color_order(ORDER_RGB);
        src_idle_pct  = 88;
        sink_idle_pct = 23;
        long_run($urandom_range(256, 260));
        random_traffic(90);
        drain();

        // No idling on either side.
        set_color_order(ORDER_GRB);
        src_idle_pct  = 0;
        sink_idle_pct = 0;
        random_traffic(90);
        drain();

        if (board.faults == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

[rgb565_run_length_encoder_core.f]
hw/rtl/rle565_pkg.sv
hw/rtl/rle565_pix_if.sv
hw/rtl/rle565_rec_if.sv
hw/rtl/rgb565_run_length_encoder_core.sv
hw/rtl/rle565_chk.sv
bench/tb.sv
